/* hdl/gb5_pkg.sv */
// ---------------------------------------------------------------------------
// gb5_pkg: shared constants and types of the 5x5 Gaussian blur unit
// Widths, register indexes, pipeline structs and the tap class lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package gb5_pkg;

   localparam int KERNEL_SIZE    = 5;
   localparam int HALF           = KERNEL_SIZE / 2;
   localparam int LINES          = KERNEL_SIZE - 1;
   localparam int SLOT_BITS      = $clog2(LINES);
   localparam int MAX_WIDTH      = 2048;
   localparam int MAX_HEIGHT     = 2048;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int DIM_BITS       = 12;
   localparam int POS_BITS       = DIM_BITS + 2;
   localparam int PIX_BITS       = 24;
   localparam int CHANNELS       = 3;
   localparam int COEF_BITS      = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int NUM_CLASSES    = 6;
   localparam int CLASS_SUM_BITS = 11;
   localparam int PROD_BITS      = COEF_BITS + CLASS_SUM_BITS;
   localparam int ACC_BITS       = PROD_BITS + 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_IMAGE_WIDTH    = 3'd0,
      REG_IMAGE_HEIGHT   = 3'd1,
      REG_COEF_CENTER    = 3'd2,
      REG_COEF_EDGE_NEAR = 3'd3,
      REG_COEF_DIAG_NEAR = 3'd4,
      REG_COEF_EDGE_FAR  = 3'd5,
      REG_COEF_KNIGHT    = 3'd6,
      REG_COEF_CORNER    = 3'd7
   } csr_index_type;

   typedef logic [PIX_BITS-1:0] pixel_type;
   // Entry j holds the pixel of row r-j at one column; entry 0 is the newest row.
   typedef logic [KERNEL_SIZE-1:0][PIX_BITS-1:0] column_type;
   typedef logic [LINES:1][PIX_BITS-1:0] stack_type;
   typedef logic [NUM_CLASSES-1:0][COEF_BITS-1:0] coef_set_type;
   typedef logic [CHANNELS-1:0][NUM_CLASSES-1:0][CLASS_SUM_BITS-1:0] class_sums_type;

   // row_ok[j] covers row offset HALF-j, col_ok[k] covers column offset HALF-k.
   typedef struct packed {
      logic [KERNEL_SIZE-1:0] row_ok;
      logic [KERNEL_SIZE-1:0] col_ok;
      logic                   emit;
      logic                   frame_end;
   } tap_ctl_type;

   // Coefficient class of a tap by its squared distance, or -1 for none.
   function automatic int class_of(input int d2);
      int cls;
      case (d2)
         0:       cls = 0;
         1:       cls = 1;
         2:       cls = 2;
         4:       cls = 3;
         5:       cls = 4;
         8:       cls = 5;
         default: cls = -1;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

/* hdl/gaussian_blur_5x5_unit.sv */
// ---------------------------------------------------------------------------
// gaussian_blur_5x5_unit: streaming 5x5 Gaussian blur of an RGB888 raster
// Zero-padded borders, six class weights in Q0.16, truncated and clamped.
//
//   channel | direction | contents
//   req_*   | in        | tdata: red, green, blue; tuser: flush tick
//   rsp_*   | out       | tdata: red, green, blue; tlast: last pixel of frame
//   csr_*   | in        | register writes, index 0..7
//
// One word is taken per clock while req_tready is high; a word runs through four register stages
// (line memory read, window class sums, multiply, sum and clamp).
// Results trail the input by two rows plus two pixels; 2*width+2 flush
// words after a frame drain it. A stalled output holds only the stages
// that are full; empty stages keep accepting. Reset needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_5x5_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [23:0]                          req_tdata,  // red_in, green_in, blue_in
   input  wire                                  req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [23:0]                          rsp_tdata,  // red_out, green_out, blue_out
   output logic                                 rsp_tlast,
   input  wire                                  csr_wr_en,
   input  wire  [gb5_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire  [gb5_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import gb5_pkg::*;

   logic [DIM_BITS-1:0]  width_ff, height_ff;
   coef_set_type         coef_ff;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [DIM_BITS-1:0]  row_ff, row_in;
   logic [DIM_BITS-1:0]  w, h;
   logic [COL_BITS-1:0]  c;
   logic                 accept;
   pixel_type            pix;
   tap_ctl_type          ctl;
   stack_type            stack;
   logic                 s1_ready, s3_ready, s2_valid, s2_frame_end;
   class_sums_type       s2_sums;
   logic                 restart;

   always_comb begin
      if (width_ff == '0) begin
         w = DIM_BITS'(1);
      end else if (width_ff > DIM_BITS'(MAX_WIDTH)) begin
         w = DIM_BITS'(MAX_WIDTH);
      end else begin
         w = width_ff;
      end
      if (height_ff == '0) begin
         h = DIM_BITS'(1);
      end else if (height_ff > DIM_BITS'(MAX_HEIGHT)) begin
         h = DIM_BITS'(MAX_HEIGHT);
      end else begin
         h = height_ff;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign req_tready = s1_ready;
   assign c = ({1'b0, col_ff} >= w) ? '0 : col_ff;
   assign pix = (!req_tuser && row_ff < h) ? req_tdata : '0;

   // Window center sits HALF rows and HALF pixels behind the input position.
   always_comb begin
      logic signed [POS_BITS-1:0] er, ec, y, x;
      logic signed [POS_BITS-1:0] hs, ws;
      er = signed'(POS_BITS'(row_ff)) - POS_BITS'(HALF);
      ec = signed'(POS_BITS'(c));
      hs = signed'(POS_BITS'(h));
      ws = signed'(POS_BITS'(w));
      for (int k = 0; k < HALF; k++) begin
         if (ec == '0) begin
            ec = ws - POS_BITS'(1);
            er = er - POS_BITS'(1);
         end else begin
            ec = ec - POS_BITS'(1);
         end
      end
      for (int j = 0; j < KERNEL_SIZE; j++) begin
         y = er + POS_BITS'(HALF) - POS_BITS'(j);
         x = ec + POS_BITS'(HALF) - POS_BITS'(j);
         ctl.row_ok[j] = (y >= 0) && (y < hs);
         ctl.col_ok[j] = (x >= 0) && (x < ws);
      end
      ctl.emit      = (er >= 0) && (er < hs);
      ctl.frame_end = (er == hs - POS_BITS'(1)) && (ec == ws - POS_BITS'(1));
   end

   always_comb begin
      logic [DIM_BITS-1:0] c_next;
      c_next = DIM_BITS'(c) + DIM_BITS'(1);
      if (c_next >= w) begin
         col_in = '0;
         row_in = row_ff + DIM_BITS'(1);
      end else begin
         col_in = c_next[COL_BITS-1:0];
         row_in = row_ff;
      end
      if (ctl.emit && ctl.frame_end) begin
         col_in = '0;
         row_in = '0;
      end
   end

   assign restart = csr_wr_en && (csr_index == REG_IMAGE_WIDTH
                                  || csr_index == REG_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(640);
         height_ff <= DIM_BITS'(480);
         coef_ff   <= {16'd2307, 16'd2534, 16'd2614, 16'd2783, 16'd2871, 16'd2962};
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_IMAGE_WIDTH:    width_ff  <= csr_wdata[DIM_BITS-1:0];
               REG_IMAGE_HEIGHT:   height_ff <= csr_wdata[DIM_BITS-1:0];
               REG_COEF_CENTER:    coef_ff[0] <= csr_wdata;
               REG_COEF_EDGE_NEAR: coef_ff[1] <= csr_wdata;
               REG_COEF_DIAG_NEAR: coef_ff[2] <= csr_wdata;
               REG_COEF_EDGE_FAR:  coef_ff[3] <= csr_wdata;
               REG_COEF_KNIGHT:    coef_ff[4] <= csr_wdata;
               REG_COEF_CORNER:    coef_ff[5] <= csr_wdata;
               default: ;
            endcase
         end
         if (restart) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   gb5_line_store u_line_store (
      .clock    (clock),
      .wr_en    (accept),
      .col_addr (c),
      .wr_slot  (row_ff[SLOT_BITS-1:0]),
      .wr_data  (pix),
      .stack    (stack)
   );

   gb5_window u_window (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pix_in       (pix),
      .ctl_in       (ctl),
      .stack        (stack),
      .s3_ready     (s3_ready),
      .s1_ready     (s1_ready),
      .s2_valid     (s2_valid),
      .s2_sums      (s2_sums),
      .s2_frame_end (s2_frame_end)
   );

   gb5_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .s2_valid     (s2_valid),
      .s2_sums      (s2_sums),
      .s2_frame_end (s2_frame_end),
      .coefs        (coef_ff),
      .s3_ready     (s3_ready),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (rsp_tdata),
      .out_last     (rsp_tlast)
   );

endmodule

`default_nettype wire

/* hdl/gb5_line_store.sv */
// ---------------------------------------------------------------------------
// gb5_line_store: four line memories of the blur unit
// One bank per buffered row; all banks read at the input column, one written.
// ---------------------------------------------------------------------------
`default_nettype none

module gb5_line_store (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire  [gb5_pkg::COL_BITS-1:0]    col_addr,
   input  wire  [gb5_pkg::SLOT_BITS-1:0]   wr_slot,
   input  wire  gb5_pkg::pixel_type        wr_data,
   output gb5_pkg::stack_type              stack
);
   import gb5_pkg::*;

   pixel_type             rd_ff [LINES];
   logic [SLOT_BITS-1:0]  slot_ff;

   for (genvar b = 0; b < LINES; b++) begin : g_bank
      pixel_type mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            rd_ff[b] <= mem[col_addr];
            if (wr_slot == SLOT_BITS'(b)) begin
               mem[col_addr] <= wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff <= wr_slot;
      end
   end

   // Row r-j lives in bank (r-j) mod LINES.
   always_comb begin
      for (int j = 1; j <= LINES; j++) begin
         stack[j] = rd_ff[SLOT_BITS'(slot_ff - SLOT_BITS'(j))];
      end
   end

endmodule

`default_nettype wire

/* hdl/gb5_window.sv */
// ---------------------------------------------------------------------------
// gb5_window: 5x5 window and per-class tap sums
// Holds the newest column, shifts the window and adds masked taps by class.
// ---------------------------------------------------------------------------
`default_nettype none

module gb5_window (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  wire  gb5_pkg::pixel_type     pix_in,
   input  wire  gb5_pkg::tap_ctl_type   ctl_in,
   input  wire  gb5_pkg::stack_type     stack,
   input  wire                          s3_ready,
   output logic                         s1_ready,
   output logic                         s2_valid,
   output gb5_pkg::class_sums_type      s2_sums,
   output logic                         s2_frame_end
);
   import gb5_pkg::*;

   logic            v1_ff, v1_in;
   pixel_type       pix1_ff;
   tap_ctl_type     ctl1_ff;
   column_type      win_ff [1:KERNEL_SIZE-1];
   column_type      col0;
   logic            v2_ff, v2_in;
   class_sums_type  sums_ff, sums_in;
   logic            fe2_ff;
   logic            s2_ready;
   logic            s1_leave;

   assign s2_ready = !v2_ff || s3_ready;
   assign s1_ready = !v1_ff || !ctl1_ff.emit || s2_ready;
   assign s1_leave = v1_ff && (!ctl1_ff.emit || s2_ready);
   assign v1_in    = s1_ready ? accept : v1_ff;
   assign v2_in    = s2_ready ? (v1_ff && ctl1_ff.emit) : v2_ff;

   always_comb begin
      col0[0] = pix1_ff;
      for (int j = 1; j < KERNEL_SIZE; j++) begin
         col0[j] = stack[j];
      end
   end

   always_comb begin
      column_type col;
      int         cls;
      int         d2;
      sums_in = '0;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
         col = (k == 0) ? col0 : win_ff[k];
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            d2  = (HALF - k) * (HALF - k) + (HALF - j) * (HALF - j);
            cls = class_of(d2);
            if (cls >= 0 && ctl1_ff.row_ok[j] && ctl1_ff.col_ok[k]) begin
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  sums_in[ch][cls] = sums_in[ch][cls]
                     + CLASS_SUM_BITS'(col[j][8*ch +: 8]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && s1_ready) begin
         pix1_ff <= pix_in;
         ctl1_ff <= ctl_in;
      end
      if (s1_leave) begin
         win_ff[1] <= col0;
         for (int k = 2; k < KERNEL_SIZE; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
      if (s2_ready && v1_ff && ctl1_ff.emit) begin
         sums_ff <= sums_in;
         fe2_ff  <= ctl1_ff.frame_end;
      end
   end

   assign s2_valid     = v2_ff;
   assign s2_sums      = sums_ff;
   assign s2_frame_end = fe2_ff;

endmodule

`default_nettype wire

/* hdl/gb5_mac.sv */
// ---------------------------------------------------------------------------
// gb5_mac: coefficient multiply, sum and saturation
// One product per class and channel, then a sum, shift and clamp to 8 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module gb5_mac (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              s2_valid,
   input  wire  gb5_pkg::class_sums_type    s2_sums,
   input  wire                              s2_frame_end,
   input  wire  gb5_pkg::coef_set_type      coefs,
   output logic                             s3_ready,
   output logic                             out_valid,
   input  wire                              out_ready,
   output logic [gb5_pkg::PIX_BITS-1:0]     out_data,
   output logic                             out_last
);
   import gb5_pkg::*;

   logic                                           v3_ff, v4_ff;
   logic [CHANNELS-1:0][NUM_CLASSES-1:0][PROD_BITS-1:0] prod_ff;
   logic                                           fe3_ff, fe4_ff;
   logic [PIX_BITS-1:0]                            data4_ff, data4_in;
   logic                                           s4_ready;

   assign s4_ready = !v4_ff || out_ready;
   assign s3_ready = !v3_ff || s4_ready;

   always_comb begin
      logic [ACC_BITS-1:0] acc;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         acc = '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            acc = acc + ACC_BITS'(prod_ff[ch][i]);
         end
         if (|acc[ACC_BITS-1:COEF_FRAC_BITS+8]) begin
            data4_in[8*ch +: 8] = 8'hFF;
         end else begin
            data4_in[8*ch +: 8] = acc[COEF_FRAC_BITS +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            v3_ff <= s2_valid;
         end
         if (s4_ready) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
               prod_ff[ch][i] <= coefs[i] * s2_sums[ch][i];
            end
         end
         fe3_ff <= s2_frame_end;
      end
      if (s4_ready && v3_ff) begin
         data4_ff <= data4_in;
         fe4_ff   <= fe3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = data4_ff;
   assign out_last  = fe4_ff;

endmodule

`default_nettype wire
